// ===== sv/pbwd_pkg.sv =====
`default_nettype none

package pbwd_pkg;

  // Number of overview points (buckets) per clip; fixes the index width
  localparam int unsigned POINTS      = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned POINTS_LOG2 = 10;

  // Configuration register widths
  localparam int unsigned LEN_W     = 40;
  localparam int unsigned CHN_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = LEN_W;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(48000);
  localparam logic [CHN_W-1:0] CHN_RESET = CHN_W'(1);

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LENGTH   = 1'b0,
    CFG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/peak_bucket_waveform_decimator.sv =====
`default_nettype none

// Channel     Dir  Handshake                  Payload
// s_axis      in   tvalid/tready              tdata: sample_value
// m_axis      out  tvalid/tready              tdata: bucket_index, peak; tlast: last_bucket
// cfg         in   cfg_we (no wait)           cfg_index, cfg_data
//
// One sample per cycle sustained. The sample's magnitude is taken on entry
// to the input register; from there the bucket update (two parallel 40-bit
// increments and compares) runs into the output register. Synchronous
// active-high reset clears counters and valid flags, loads clip_length 48000,
// channel_count 1. A stalled output register holds the input register, so
// s_axis_tready drops.

module peak_bucket_waveform_decimator #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // slave stream: [SAMPLE_BITS-1:0] sample_value, zero-padded to bytes
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // master stream: [9:0] bucket_index, [SAMPLE_BITS+8:10] peak, zero-padded
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [((pbwd_pkg::IDX_W+SAMPLE_BITS-1+7)/8)*8-1:0] m_axis_tdata,
  output logic                                  m_axis_tlast,
  // configuration write port
  input  wire                                   cfg_we,
  input  wire  [pbwd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [pbwd_pkg::CFG_W-1:0]            cfg_data
);
  import pbwd_pkg::*;

  localparam int unsigned OUT_W = ((IDX_W + SAMPLE_BITS - 1 + 7) / 8) * 8;
  localparam int unsigned PK_W  = SAMPLE_BITS - 1;
  localparam int unsigned PW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CW    = (PW > CHN_W) ? PW : CHN_W;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [LEN_W-1:0] clip_length;
  logic [CHN_W-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_length   <= LEN_RESET;
      channel_count <= CHN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CLIP_LENGTH:   clip_length   <= cfg_data[LEN_W-1:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CHN_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived clip geometry
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] spb;
  logic [IDX_W-1:0] last_idx;
  logic [CW-1:0]    chan_cnt_x;
  logic [CW-1:0]    chans;

  always_comb begin
    len_eff  = (clip_length == '0) ? LEN_W'(1) : clip_length;
    spb      = len_eff >> POINTS_LOG2;
    if (spb == '0) spb = LEN_W'(1);
    last_idx = (len_eff < LEN_W'(POINTS)) ? IDX_W'(len_eff - LEN_W'(1))
                                          : IDX_W'(POINTS - 1);
    chan_cnt_x = CW'(channel_count);
    if (chan_cnt_x == '0)
      chans = CW'(1);
    else if (chan_cnt_x > CW'(MAX_CHANNELS))
      chans = CW'(MAX_CHANNELS);
    else
      chans = chan_cnt_x;
  end

  // ---------------------------------------------------------------
  // Input register: holds the sample's magnitude
  logic            s1_valid;
  logic [PK_W-1:0] s1_mag;
  logic            proc_en;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] smp_neg;
  logic [PK_W-1:0]               mag;

  always_comb begin
    smp     = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    smp_neg = -smp;
    if (!smp[SAMPLE_BITS-1])
      mag = smp[PK_W-1:0];
    else if (smp == {1'b1, {PK_W{1'b0}}})
      mag = '1;                 // most negative value saturates
    else
      mag = smp_neg[PK_W-1:0];
  end

  assign proc_en       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || proc_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) s1_mag <= mag;
  end

  // ---------------------------------------------------------------
  // Bucket state and update
  logic [IDX_W-1:0] bucket_counter, bucket_counter_next;
  logic [LEN_W-1:0] frames_in_bucket, frames_in_bucket_next;
  logic [LEN_W-1:0] frames_total, frames_total_next;
  logic [PW-1:0]    channel_position, channel_position_next;
  logic [PK_W-1:0]  running_peak, running_peak_next;

  logic [PK_W-1:0]  peak_upd;
  logic [LEN_W-1:0] fib_inc;
  logic [LEN_W-1:0] ftot_inc;
  logic             frame_end;
  logic             is_last;
  logic             done;

  always_comb begin
    peak_upd  = (s1_mag > running_peak) ? s1_mag : running_peak;
    frame_end = (CW'(channel_position) + CW'(1)) >= chans;
    fib_inc   = frames_in_bucket + LEN_W'(1);
    ftot_inc  = frames_total + LEN_W'(1);
    is_last   = bucket_counter >= last_idx;
    done      = frame_end && (is_last ? (ftot_inc >= len_eff) : (fib_inc >= spb));

    bucket_counter_next   = bucket_counter;
    frames_in_bucket_next = frames_in_bucket;
    frames_total_next     = frames_total;
    channel_position_next = channel_position + PW'(1);
    running_peak_next     = peak_upd;

    if (frame_end) begin
      channel_position_next = '0;
      frames_in_bucket_next = fib_inc;
      frames_total_next     = ftot_inc;
    end
    if (done) begin
      running_peak_next     = '0;
      frames_in_bucket_next = '0;
      if (is_last) begin
        // clip finished: restart for the next one
        bucket_counter_next = '0;
        frames_total_next   = '0;
      end else begin
        bucket_counter_next = bucket_counter + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_counter   <= '0;
      frames_in_bucket <= '0;
      frames_total     <= '0;
      channel_position <= '0;
      running_peak     <= '0;
    end else if (proc_en) begin
      bucket_counter   <= bucket_counter_next;
      frames_in_bucket <= frames_in_bucket_next;
      frames_total     <= frames_total_next;
      channel_position <= channel_position_next;
      running_peak     <= running_peak_next;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  logic [IDX_W-1:0] out_index;
  logic [PK_W-1:0]  out_peak;
  logic             out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc_en) begin
      m_axis_tvalid <= done;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && done) begin
      out_index <= bucket_counter;
      out_peak  <= peak_upd;
      out_last  <= is_last;
    end
  end

  assign m_axis_tdata = OUT_W'({out_peak, out_index});
  assign m_axis_tlast = out_last;

  // ---------------------------------------------------------------
  // Assertions
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    CW'(channel_position) < CW'(MAX_CHANNELS))
    else $error("channel position beyond channel limit");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    proc_en && done && is_last |=> bucket_counter == '0 && frames_total == '0)
    else $error("counters not restarted after final bucket");

  a_bucket_step: assert property (@(posedge clk) disable iff (rst)
    proc_en && done && !is_last |=> bucket_counter == $past(bucket_counter) + IDX_W'(1))
    else $error("bucket counter did not advance");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(proc_en))
    else $error("result appeared without a bucket update");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
